/* rtl/core/sorted_repeating_timer_queue_assert.svh */
// Assertion macros for the sorted repeating timer queue.
// Used by srtq_ctrl and sorted_repeating_timer_queue; expects clk and rst_n in scope.
`ifndef SORTED_REPEATING_TIMER_QUEUE_ASSERT_SVH
`define SORTED_REPEATING_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SRTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/srtq_pkg.sv */
// Shared types and constants for the sorted repeating timer queue.
// No dependencies.
package srtq_pkg;

    localparam int ID_W             = 4;
    localparam int FUNC_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int DELAY_W          = 32;
    localparam int NOW_W            = 32;
    localparam int REPEAT_W         = 8;
    localparam int NUM_SLOTS        = 1 << ID_W;
    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_TIME_WIDTH   = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_SCHEDULE = 2'd0,
        FN_REMOVE   = 2'd1,
        FN_TICK     = 2'd2,
        FN_DEFUNCT  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_DONE    = 2'd0,
        RS_FIRED   = 2'd1,
        RS_DROPPED = 2'd2,
        RS_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_POP    = 2'd3
    } chain_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_RESULT,
        S_HEAD,
        S_REQUEUE
    } state_t;

    // command broadcast to every cell
    typedef struct packed {
        chain_op_t       op;
        logic [ID_W-1:0] id;
    } chain_cmd_t;

    // what the controller sees of the chain
    typedef struct packed {
        logic            head_valid;
        logic [ID_W-1:0] head_id;
        logic            full;
    } chain_stat_t;

endpackage

/* rtl/core/srtq_cell.sv */
// One queue cell: holds a due time, a timer id and a valid bit.
// Depends on srtq_pkg.
module srtq_cell #(
    parameter int TIME_WIDTH = srtq_pkg::DEF_TIME_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  srtq_pkg::chain_cmd_t      cmd,
    input  logic [TIME_WIDTH-1:0]     key_time,
    input  logic                      prev_at_or_before,
    input  logic                      prev_valid,
    input  logic [TIME_WIDTH-1:0]     prev_due,
    input  logic [srtq_pkg::ID_W-1:0] prev_id,
    input  logic                      next_valid,
    input  logic [TIME_WIDTH-1:0]     next_due,
    input  logic [srtq_pkg::ID_W-1:0] next_id,
    input  logic                      hit_in,
    output logic                      at_or_before,
    output logic                      hit_out,
    output logic                      valid,
    output logic [TIME_WIDTH-1:0]     due,
    output logic [srtq_pkg::ID_W-1:0] id
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [TIME_WIDTH-1:0]     due_reg;
    logic [TIME_WIDTH-1:0]     due_next;
    logic [srtq_pkg::ID_W-1:0] id_reg;
    logic [srtq_pkg::ID_W-1:0] id_next;

    // ids are unique in the queue, so at most one cell hits
    assign at_or_before = valid_reg && (due_reg <= key_time);
    assign hit_out      = hit_in || (valid_reg && (id_reg == cmd.id));

    always_comb
    begin
        valid_next = valid_reg;
        due_next   = due_reg;
        id_next    = id_reg;
        unique case (cmd.op)
            srtq_pkg::OP_NOP:
            begin
            end
            srtq_pkg::OP_INSERT:
            begin
                valid_next = prev_valid;
                if (!at_or_before)
                begin
                    if (prev_at_or_before)
                    begin
                        due_next = key_time;
                        id_next  = cmd.id;
                    end
                    else
                    begin
                        due_next = prev_due;
                        id_next  = prev_id;
                    end
                end
            end
            srtq_pkg::OP_DELETE:
            begin
                if (hit_out)
                begin
                    valid_next = next_valid;
                    due_next   = next_due;
                    id_next    = next_id;
                end
            end
            srtq_pkg::OP_POP:
            begin
                valid_next = next_valid;
                due_next   = next_due;
                id_next    = next_id;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        due_reg <= due_next;
        id_reg  <= id_next;
    end

    assign valid = valid_reg;
    assign due   = due_reg;
    assign id    = id_reg;

endmodule

/* rtl/core/srtq_ctrl.sv */
// Sequencer for the timer queue: slot tables, tick walk and result register.
// Depends on srtq_pkg and sorted_repeating_timer_queue_assert.svh.
`include "sorted_repeating_timer_queue_assert.svh"

module srtq_ctrl #(
    parameter int TIME_WIDTH = srtq_pkg::DEF_TIME_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [srtq_pkg::FUNC_W-1:0]   func,
    input  logic [srtq_pkg::ID_W-1:0]     timer_id,
    input  logic [srtq_pkg::DELAY_W-1:0]  delay,
    input  logic signed [srtq_pkg::REPEAT_W-1:0] repeat_req,
    input  logic                          immediate,
    input  logic [srtq_pkg::NOW_W-1:0]    now,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [srtq_pkg::STATUS_W-1:0] status,
    output logic [srtq_pkg::ID_W-1:0]     fired_id,
    output logic                          last,
    output srtq_pkg::chain_cmd_t          cmd,
    output logic [TIME_WIDTH-1:0]         key_time,
    input  srtq_pkg::chain_stat_t         stat,
    input  logic [TIME_WIDTH-1:0]         head_due
);

    localparam int NS = srtq_pkg::NUM_SLOTS;
    localparam int IW = srtq_pkg::ID_W;

    srtq_pkg::state_t              state_reg, state_next;
    logic [IW-1:0]                 id_reg, id_next;
    logic [TIME_WIDTH-1:0]         now_reg, now_next;
    logic [TIME_WIDTH-1:0]         key_time_reg, key_time_next;
    srtq_pkg::status_t             res_status_reg, res_status_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [IW-1:0]                 pend_id_reg, pend_id_next;
    logic [NS-1:0]                 fired_reg, fired_next;
    logic [NS-1:0]                 slot_defunct_reg, slot_defunct_next;
    logic [srtq_pkg::DELAY_W-1:0]  slot_delay_reg [NS];
    logic [srtq_pkg::DELAY_W-1:0]  slot_delay_next [NS];
    logic [srtq_pkg::REPEAT_W-1:0] slot_repeat_reg [NS];
    logic [srtq_pkg::REPEAT_W-1:0] slot_repeat_next [NS];
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [srtq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IW-1:0]                 fired_id_reg, fired_id_next;
    logic                          last_reg, last_next;

    logic          out_free;
    logic          out_load;
    logic [IW-1:0] h;
    logic          head_defunct;
    logic          head_late;
    logic          head_fired;
    logic          head_stop;

    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign h            = stat.head_id;
    assign head_defunct = slot_defunct_reg[h];
    assign head_late    = head_due > now_reg;
    assign head_fired   = fired_reg[h];
    assign head_stop    = !stat.head_valid || (!head_defunct && (head_late || head_fired));

    always_comb
    begin
        state_next        = state_reg;
        id_next           = id_reg;
        now_next          = now_reg;
        key_time_next     = key_time_reg;
        res_status_next   = res_status_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;
        fired_next        = fired_reg;
        slot_defunct_next = slot_defunct_reg;
        slot_delay_next   = slot_delay_reg;
        slot_repeat_next  = slot_repeat_reg;
        out_load          = 1'b0;
        status_next       = status_reg;
        fired_id_next     = fired_id_reg;
        last_next         = last_reg;
        cmd.op            = srtq_pkg::OP_NOP;
        cmd.id            = id_reg;

        unique case (state_reg)
            srtq_pkg::S_IDLE:
            begin
                cmd.id = timer_id;
                if (req_valid)
                begin
                    id_next         = timer_id;
                    now_next        = TIME_WIDTH'(now);
                    res_status_next = srtq_pkg::RS_DONE;
                    unique case (srtq_pkg::func_t'(func))
                        srtq_pkg::FN_SCHEDULE:
                        begin
                            slot_delay_next[timer_id]   = delay;
                            slot_repeat_next[timer_id]  = repeat_req;
                            slot_defunct_next[timer_id] = 1'b0;
                            key_time_next = immediate ? '0
                                          : TIME_WIDTH'(now) + TIME_WIDTH'(delay);
                            cmd.op     = srtq_pkg::OP_DELETE;
                            state_next = srtq_pkg::S_INSERT;
                        end
                        srtq_pkg::FN_REMOVE:
                        begin
                            cmd.op     = srtq_pkg::OP_DELETE;
                            state_next = srtq_pkg::S_RESULT;
                        end
                        srtq_pkg::FN_TICK:
                        begin
                            fired_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = srtq_pkg::S_HEAD;
                        end
                        srtq_pkg::FN_DEFUNCT:
                        begin
                            slot_defunct_next[timer_id] = 1'b1;
                            state_next = srtq_pkg::S_RESULT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            srtq_pkg::S_INSERT:
            begin
                if (stat.full)
                    res_status_next = srtq_pkg::RS_FULL;
                else
                    cmd.op = srtq_pkg::OP_INSERT;
                state_next = srtq_pkg::S_RESULT;
            end
            srtq_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    status_next   = res_status_reg;
                    fired_id_next = id_reg;
                    last_next     = 1'b1;
                    state_next    = srtq_pkg::S_IDLE;
                end
            end
            srtq_pkg::S_HEAD:
            begin
                // one fired word is held back until we know whether it is the last
                if (head_stop)
                begin
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        status_next     = pend_valid_reg ? srtq_pkg::RS_FIRED
                                                         : srtq_pkg::RS_DONE;
                        fired_id_next   = pend_valid_reg ? pend_id_reg : '0;
                        last_next       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = srtq_pkg::S_IDLE;
                    end
                end
                else if (head_defunct)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        if (pend_valid_reg)
                        begin
                            status_next     = srtq_pkg::RS_FIRED;
                            fired_id_next   = pend_id_reg;
                            last_next       = 1'b0;
                            pend_valid_next = 1'b0;
                        end
                        else
                        begin
                            status_next   = srtq_pkg::RS_DROPPED;
                            fired_id_next = h;
                            last_next     = 1'b1;
                            cmd.op        = srtq_pkg::OP_POP;
                            state_next    = srtq_pkg::S_IDLE;
                        end
                    end
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load      = 1'b1;
                        status_next   = srtq_pkg::RS_FIRED;
                        fired_id_next = pend_id_reg;
                        last_next     = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = h;
                    fired_next[h]   = 1'b1;
                    cmd.op          = srtq_pkg::OP_POP;
                    if (slot_repeat_reg[h] != '0)
                    begin
                        key_time_next = now_reg + TIME_WIDTH'(slot_delay_reg[h]);
                        id_next       = h;
                        // top bit set means repeat forever
                        if (!slot_repeat_reg[h][srtq_pkg::REPEAT_W-1])
                            slot_repeat_next[h] = slot_repeat_reg[h]
                                                - srtq_pkg::REPEAT_W'(1);
                        state_next = srtq_pkg::S_REQUEUE;
                    end
                end
            end
            srtq_pkg::S_REQUEUE:
            begin
                cmd.op     = srtq_pkg::OP_INSERT;
                state_next = srtq_pkg::S_HEAD;
            end
            default:
            begin
                state_next = srtq_pkg::S_IDLE;
            end
        endcase

        if (out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= srtq_pkg::S_IDLE;
            pend_valid_reg   <= 1'b0;
            fired_reg        <= '0;
            slot_defunct_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_valid_reg   <= pend_valid_next;
            fired_reg        <= fired_next;
            slot_defunct_reg <= slot_defunct_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        now_reg         <= now_next;
        key_time_reg    <= key_time_next;
        res_status_reg  <= res_status_next;
        pend_id_reg     <= pend_id_next;
        slot_delay_reg  <= slot_delay_next;
        slot_repeat_reg <= slot_repeat_next;
        status_reg      <= status_next;
        fired_id_reg    <= fired_id_next;
        last_reg        <= last_next;
    end

    assign req_stall = (state_reg != srtq_pkg::S_IDLE);
    assign key_time  = key_time_reg;
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign fired_id  = fired_id_reg;
    assign last      = last_reg;

    `SRTQ_ASSERT_NOW(a_pend_only_in_tick, state_reg == srtq_pkg::S_IDLE, !pend_valid_reg, "held fired word outside a tick")
    `SRTQ_ASSERT_NEXT(a_last_ends_item, out_load && last_next, state_reg == srtq_pkg::S_IDLE, "final word did not end the item")
    `SRTQ_ASSERT_NOW(a_requeue_after_pop, state_reg == srtq_pkg::S_REQUEUE, pend_valid_reg && (pend_id_reg == id_reg), "requeue of a timer that did not just fire")

endmodule

/* rtl/core/sorted_repeating_timer_queue.sv */
// Sorted repeating timer queue: a row of QUEUE_DEPTH cells kept in due-time order.
// A remove or mark-defunct passes through S_RESULT, a schedule through S_INSERT and then
// S_RESULT, where the word waits while the output is stalled. A tick pops each fired timer
// in S_HEAD, with a requeue in S_REQUEUE for a repeating one, then sends the final word (a
// defunct drop is that word); up to 16 words, one per cycle at most. One item at a time.
// Reset (rst_n, asynchronous, active low) empties the queue and clears all defunct flags.
`include "sorted_repeating_timer_queue_assert.svh"

module sorted_repeating_timer_queue #(
    parameter int QUEUE_DEPTH = srtq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_WIDTH  = srtq_pkg::DEF_TIME_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [srtq_pkg::FUNC_W-1:0]   func,
    input  logic [srtq_pkg::ID_W-1:0]     timer_id,
    input  logic [srtq_pkg::DELAY_W-1:0]  delay,
    input  logic signed [srtq_pkg::REPEAT_W-1:0] repeat_req,
    input  logic                          immediate,
    input  logic [srtq_pkg::NOW_W-1:0]    now,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [srtq_pkg::STATUS_W-1:0] status,
    output logic [srtq_pkg::ID_W-1:0]     fired_id,
    output logic                          last
);

    // Each cell compares its own due time against the broadcast key and looks only at
    // its neighbours: insert shifts the tail down by one, delete and pop shift up.
    // The delete hit ripples down the row as a one-bit prefix so the matching cell and every
    // cell past it pull from their successor. Valid cells are always packed from the head.

    srtq_pkg::chain_cmd_t          cmd;
    srtq_pkg::chain_stat_t         stat;
    logic [TIME_WIDTH-1:0]         key_time;

    logic [QUEUE_DEPTH-1:0]        cell_valid;
    logic [QUEUE_DEPTH-1:0]        cell_le;
    logic [QUEUE_DEPTH-1:0]        cell_hit;
    logic [TIME_WIDTH-1:0]         cell_due [QUEUE_DEPTH];
    logic [srtq_pkg::ID_W-1:0]     cell_id  [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                      p_le;
        logic                      p_valid;
        logic [TIME_WIDTH-1:0]     p_due;
        logic [srtq_pkg::ID_W-1:0] p_id;
        logic                      n_valid;
        logic [TIME_WIDTH-1:0]     n_due;
        logic [srtq_pkg::ID_W-1:0] n_id;
        logic                      h_in;

        if (i == 0)
        begin : g_head
            // ahead of the head sits a virtual cell that is valid and always earlier
            assign p_le    = 1'b1;
            assign p_valid = 1'b1;
            assign p_due   = '0;
            assign p_id    = '0;
            assign h_in    = 1'b0;
        end
        else
        begin : g_body
            assign p_le    = cell_le[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_due   = cell_due[i-1];
            assign p_id    = cell_id[i-1];
            assign h_in    = cell_hit[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_due   = '0;
            assign n_id    = '0;
        end
        else
        begin : g_mid
            assign n_valid = cell_valid[i+1];
            assign n_due   = cell_due[i+1];
            assign n_id    = cell_id[i+1];
        end

        srtq_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk               (clk),
            .rst_n             (rst_n),
            .cmd               (cmd),
            .key_time          (key_time),
            .prev_at_or_before (p_le),
            .prev_valid        (p_valid),
            .prev_due          (p_due),
            .prev_id           (p_id),
            .next_valid        (n_valid),
            .next_due          (n_due),
            .next_id           (n_id),
            .hit_in            (h_in),
            .at_or_before      (cell_le[i]),
            .hit_out           (cell_hit[i]),
            .valid             (cell_valid[i]),
            .due               (cell_due[i]),
            .id                (cell_id[i])
        );
    end

    assign stat.head_valid = cell_valid[0];
    assign stat.head_id    = cell_id[0];
    assign stat.full       = cell_valid[QUEUE_DEPTH-1];

    srtq_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .timer_id   (timer_id),
        .delay      (delay),
        .repeat_req (repeat_req),
        .immediate  (immediate),
        .now        (now),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .fired_id   (fired_id),
        .last       (last),
        .cmd        (cmd),
        .key_time   (key_time),
        .stat       (stat),
        .head_due   (cell_due[0])
    );

    // packed from the head: the valid vector is always of the form 0..01..1
    `SRTQ_ASSERT_NOW(a_row_packed, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0, "hole in the cell row")
    `SRTQ_ASSERT_NOW(a_no_insert_full, cmd.op == srtq_pkg::OP_INSERT, !cell_valid[QUEUE_DEPTH-1], "insert into a full row")
    `SRTQ_ASSERT_NEXT(a_pop_shrinks, cmd.op == srtq_pkg::OP_POP, $countones(cell_valid) == $countones($past(cell_valid)) - 1, "pop did not remove one cell")

endmodule
